[design/rotating_key_xor_cipher_unit_assert.svh]
// assertion macros for the rotating key xor cipher unit
// used by modules that have clk_i and rst_ni in scope
`ifndef ROTATING_KEY_XOR_CIPHER_UNIT_ASSERT_SVH
`define ROTATING_KEY_XOR_CIPHER_UNIT_ASSERT_SVH

// same-cycle implication
`define RKX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rkx assertion failed");

// next-cycle implication
`define RKX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rkx assertion failed");

`endif

[design/rkx_pkg.sv]
// shared constants and types for the rotating key xor cipher unit
// no dependencies
`timescale 1ns / 1ps

package rkx_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int KEY_WORDS   = 4;
  localparam int KEY_BYTES_W = 6;
  localparam int CFG_KEY_W   = KEY_WORDS * CFG_DATA_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD_0 = 3'd0,
    REG_KEY_WORD_1 = 3'd1,
    REG_KEY_WORD_2 = 3'd2,
    REG_KEY_WORD_3 = 3'd3,
    REG_KEY_BYTES  = 3'd4
  } cfg_reg_e;

endpackage

[design/rkx_if.sv]
// channel interfaces: plaintext items, ciphertext items, config writes
// depends on rkx_pkg
`timescale 1ns / 1ps

interface rkx_plain_if
  import rkx_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] plain_byte;

  modport source (output valid, output plain_byte, input ready);
  modport sink   (input valid, input plain_byte, output ready);
endinterface

interface rkx_cipher_if
  import rkx_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] cipher_byte;

  modport source (output valid, output cipher_byte, input ready);
  modport sink   (input valid, input cipher_byte, output ready);
endinterface

interface rkx_cfg_if
  import rkx_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/rkx_key_ctrl.sv]
// config registers, working key, byte position and key rotation
// depends on rkx_pkg, rkx_if, rotating_key_xor_cipher_unit_assert.svh
`timescale 1ns / 1ps
`include "rotating_key_xor_cipher_unit_assert.svh"

module rkx_key_ctrl
  import rkx_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rkx_cfg_if.sink           cfg,
  input  logic              advance_i,
  output logic [BYTE_W-1:0] key_byte_o
);

  localparam int KeyW = MAX_KEY_BYTES * BYTE_W;
  localparam int PosW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int CmpW = KEY_BYTES_W + 2;

  logic [CFG_DATA_W-1:0] key_word_q [KEY_WORDS];
  logic [CFG_DATA_W-1:0] key_word_d [KEY_WORDS];
  logic [CFG_KEY_W-1:0]  key_flat;
  logic [KeyW-1:0]       key_load;
  logic [KeyW-1:0]       wkey_q, wkey_d, wkey_rot, wkey_shl;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [PosW-1:0]       last_q, last_d;
  logic                  cfg_fire, reload, at_last, wrap;
  logic [KEY_BYTES_W-1:0] kb;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign kb        = cfg.data[KEY_BYTES_W-1:0];

  always_comb begin
    for (int w = 0; w < KEY_WORDS; w++) begin
      key_word_d[w] = key_word_q[w];
    end
    last_d = last_q;
    reload = 1'b0;
    if (cfg_fire) begin
      case (cfg_reg_e'(cfg.index))
        REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3: begin
          key_word_d[cfg.index[1:0]] = cfg.data;
          reload = 1'b1;
        end
        REG_KEY_BYTES: begin
          reload = 1'b1;
          if (kb == '0) begin
            last_d = '0;
          end else if (CmpW'(kb) > CmpW'(MAX_KEY_BYTES)) begin
            last_d = PosW'(MAX_KEY_BYTES - 1);
          end else begin
            last_d = PosW'(kb - 1'b1);
          end
        end
        default: reload = 1'b0;
      endcase
    end
  end

  always_comb begin
    for (int w = 0; w < KEY_WORDS; w++) begin
      key_flat[w*CFG_DATA_W +: CFG_DATA_W] = key_word_d[w];
    end
  end

  if (KeyW <= CFG_KEY_W) begin : g_load_trunc
    assign key_load = key_flat[KeyW-1:0];
  end else begin : g_load_ext
    assign key_load = {{(KeyW - CFG_KEY_W){1'b0}}, key_flat};
  end

  // rotate left by one bit over the active bytes only
  assign at_last  = (pos_q == last_q);
  assign wrap     = wkey_q[{last_q, 3'd7}];
  assign wkey_shl = {wkey_q[KeyW-2:0], wrap};

  always_comb begin
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (PosW'(i) <= last_q) begin
        wkey_rot[i*BYTE_W +: BYTE_W] = wkey_shl[i*BYTE_W +: BYTE_W];
      end else begin
        wkey_rot[i*BYTE_W +: BYTE_W] = wkey_q[i*BYTE_W +: BYTE_W];
      end
    end
  end

  always_comb begin
    wkey_d = wkey_q;
    pos_d  = pos_q;
    if (reload) begin
      wkey_d = key_load;
      pos_d  = '0;
    end else if (advance_i) begin
      if (at_last) begin
        wkey_d = wkey_rot;
        pos_d  = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  assign key_byte_o = wkey_q[{pos_q, 3'd0} +: BYTE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < KEY_WORDS; w++) begin
        key_word_q[w] <= '0;
      end
      wkey_q <= '0;
      pos_q  <= '0;
      last_q <= '0;
    end else begin
      for (int w = 0; w < KEY_WORDS; w++) begin
        key_word_q[w] <= key_word_d[w];
      end
      wkey_q <= wkey_d;
      pos_q  <= pos_d;
      last_q <= last_d;
    end
  end

  `RKX_ASSERT_NOW(a_pos_in_block, 1'b1, pos_q <= last_q)
  `RKX_ASSERT_NEXT(a_reload_clears_pos, reload, pos_q == '0)
  `RKX_ASSERT_NEXT(a_block_end_wraps, advance_i && at_last && !reload, pos_q == '0)

endmodule

[design/rkx_out_reg.sv]
// result register with valid flag between the cipher datapath and the sink
// depends on rkx_pkg, rkx_if, rotating_key_xor_cipher_unit_assert.svh
`timescale 1ns / 1ps
`include "rotating_key_xor_cipher_unit_assert.svh"

module rkx_out_reg
  import rkx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [BYTE_W-1:0] data_i,
  output logic              free_o,
  rkx_cipher_if.source      res
);

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] data_q;

  assign free_o = !valid_q || res.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign res.valid       = valid_q;
  assign res.cipher_byte = data_q;

  `RKX_ASSERT_NOW(a_no_overwrite, load_i, !valid_q || res.ready)
  `RKX_ASSERT_NEXT(a_load_shows, load_i, valid_q)
  `RKX_ASSERT_NEXT(a_stall_holds, valid_q && !res.ready, valid_q && $stable(data_q))

endmodule

[design/rotating_key_xor_cipher_unit.sv]
// Rotating key xor cipher unit, top level.
// Depends on rkx_pkg, rkx_if, rkx_key_ctrl and rkx_out_reg.
//
// plain_i takes one plaintext byte per item, cipher_o returns one ciphertext
// byte per item, in order. cfg_i writes the key words (index 0..3) and the
// key length in bytes (index 4); any write reloads the working key and
// restarts the block. Writes to other indexes are ignored. Write config only
// while no item is in flight.
// Each byte is xored with working key byte p; after the last byte of a block
// the active key bytes rotate left by one bit.
// The result is registered and shows the cycle after the item is taken.
// Throughput is one item per cycle while the receiver takes each result, set
// by the single result register; the key byte select, xor and rotation all
// finish within that cycle. Reset clears the key words, sets key length to
// one byte and empties the result register. If the receiver stalls, the
// result is held and plain_i ready drops until it is taken; cfg_i is always ready.
`timescale 1ns / 1ps

module rotating_key_xor_cipher_unit
  import rkx_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rkx_plain_if.sink     plain_i,
  rkx_cipher_if.source  cipher_o,
  rkx_cfg_if.sink       cfg_i
);

  logic              accept;
  logic              free;
  logic [BYTE_W-1:0] key_byte;
  logic [BYTE_W-1:0] cipher_d;

  assign plain_i.ready = free;
  assign accept        = plain_i.valid && free;
  assign cipher_d      = plain_i.plain_byte ^ key_byte;

  rkx_key_ctrl #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_key_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg       (cfg_i),
    .advance_i (accept),
    .key_byte_o(key_byte)
  );

  rkx_out_reg u_out_reg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(accept),
    .data_i(cipher_d),
    .free_o(free),
    .res   (cipher_o)
  );

endmodule
